[hdl/rsa_modular_exponentiation_unit_defines.svh]
// Assertion helpers used by the exponentiation unit controller.
`ifndef RSA_MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RSA_MEXP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RSA_MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rsa_mexp_pkg.sv]
package rsa_mexp_pkg;

  localparam int unsigned CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

  localparam logic [31:0] MODULUS_RESET  = 32'd3233;
  localparam logic [31:0] EXPONENT_RESET = 32'd17;

  typedef struct packed {
    logic load_msg;
    logic start_sq;
    logic start_mul;
    logic step;
    logic store_base;
    logic store_acc;
    logic shift_exp;
    logic load_out;
  } rsa_mexp_cmd_t;

  typedef struct packed {
    logic exp_msb;
  } rsa_mexp_status_t;

endpackage

[hdl/rsa_mexp_dpath.sv]
module rsa_mexp_dpath #(
  parameter int VALUE_BITS = 31
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [rsa_mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0]                    cfg_data,
  input  logic [VALUE_BITS-1:0]                    message_value,
  output logic [VALUE_BITS-1:0]                    result_value,
  input  rsa_mexp_pkg::rsa_mexp_cmd_t              cmd,
  output rsa_mexp_pkg::rsa_mexp_status_t           status
);
  import rsa_mexp_pkg::*;

  localparam int EW = VALUE_BITS + 3;

  logic [VALUE_BITS-1:0] modulus;
  logic [VALUE_BITS-1:0] exponent;
  logic [VALUE_BITS-1:0] exp_shift;
  logic [VALUE_BITS-1:0] base;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] mm_a;
  logic [VALUE_BITS-1:0] mm_b;
  logic [VALUE_BITS-1:0] mm_acc;
  logic [VALUE_BITS-1:0] step_val;
  logic [EW-1:0]         sum;
  logic [EW-1:0]         diff1;
  logic [EW-1:0]         diff2;
  logic                  mod_small;

  // one bit of interleaved modular multiply: 2*acc + bit*a, reduced by m or 2m
  always_comb begin
    sum   = {2'b00, mm_acc, 1'b0} + (mm_b[VALUE_BITS-1] ? {3'b000, mm_a} : '0);
    diff1 = sum - {3'b000, modulus};
    diff2 = sum - {2'b00, modulus, 1'b0};
    if (!diff2[EW-1]) begin
      step_val = diff2[VALUE_BITS-1:0];
    end else if (!diff1[EW-1]) begin
      step_val = diff1[VALUE_BITS-1:0];
    end else begin
      step_val = sum[VALUE_BITS-1:0];
    end
  end

  assign mod_small      = (modulus[VALUE_BITS-1:1] == '0);
  assign status.exp_msb = exp_shift[VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET[VALUE_BITS-1:0];
      exponent <= EXPONENT_RESET[VALUE_BITS-1:0];
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_msg) begin
      mm_a      <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
      mm_b      <= message_value;
      mm_acc    <= '0;
      exp_shift <= exponent;
      acc       <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end
    if (cmd.start_sq) begin
      mm_a   <= acc;
      mm_b   <= acc;
      mm_acc <= '0;
    end
    if (cmd.start_mul) begin
      mm_a   <= base;
      mm_b   <= acc;
      mm_acc <= '0;
    end
    if (cmd.step) begin
      mm_acc <= step_val;
      mm_b   <= {mm_b[VALUE_BITS-2:0], 1'b0};
    end
    if (cmd.store_base) begin
      base <= step_val;
    end
    if (cmd.store_acc) begin
      acc <= step_val;
    end
    if (cmd.shift_exp) begin
      exp_shift <= {exp_shift[VALUE_BITS-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      result_value <= mod_small ? '0 : acc;
    end
  end

endmodule

[hdl/rsa_mexp_ctrl.sv]
`include "rsa_modular_exponentiation_unit_defines.svh"

module rsa_mexp_ctrl #(
  parameter int VALUE_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  rsa_mexp_pkg::rsa_mexp_status_t  status,
  output rsa_mexp_pkg::rsa_mexp_cmd_t     cmd
);
  import rsa_mexp_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(VALUE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SQ_LOAD,
    S_SQUARE,
    S_MUL_LOAD,
    S_MULTIPLY,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] bit_cnt;
  logic             step_last;
  logic             bit_last;
  logic             out_free;

  assign step_last = (step_cnt == LAST);
  assign bit_last  = (bit_cnt == LAST);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load_msg = in_valid;
      end
      S_REDUCE: begin
        cmd.step       = 1'b1;
        cmd.store_base = step_last;
      end
      S_SQ_LOAD: begin
        cmd.start_sq = 1'b1;
      end
      S_SQUARE: begin
        cmd.step      = 1'b1;
        cmd.store_acc = step_last;
        cmd.shift_exp = step_last && !status.exp_msb;
      end
      S_MUL_LOAD: begin
        cmd.start_mul = 1'b1;
      end
      S_MULTIPLY: begin
        cmd.step      = 1'b1;
        cmd.store_acc = step_last;
        cmd.shift_exp = step_last;
      end
      S_FINISH: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            step_cnt <= '0;
            state    <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_last) begin
            bit_cnt <= '0;
            state   <= S_SQ_LOAD;
          end
        end
        S_SQ_LOAD: begin
          step_cnt <= '0;
          state    <= S_SQUARE;
        end
        S_SQUARE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_last) begin
            if (status.exp_msb) begin
              state <= S_MUL_LOAD;
            end else if (bit_last) begin
              state <= S_FINISH;
            end else begin
              bit_cnt <= bit_cnt + 1'b1;
              state   <= S_SQ_LOAD;
            end
          end
        end
        S_MUL_LOAD: begin
          step_cnt <= '0;
          state    <= S_MULTIPLY;
        end
        S_MULTIPLY: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_last) begin
            if (bit_last) begin
              state <= S_FINISH;
            end else begin
              bit_cnt <= bit_cnt + 1'b1;
              state   <= S_SQ_LOAD;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RSA_MEXP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                        "busy expected after accept")
  `RSA_MEXP_ASSERT_IMP(a_load_into_free_slot, cmd.load_out, out_free,
                       "result loaded over pending output")
  `RSA_MEXP_ASSERT_NEXT(a_finish_holds_on_stall,
                        (state == S_FINISH) && out_valid && !out_ready,
                        state == S_FINISH, "finish left while output stalled")
  `RSA_MEXP_ASSERT_IMP(a_store_on_last_step, cmd.store_acc || cmd.store_base,
                       step_cnt == LAST, "partial product stored early")

endmodule

[hdl/rsa_modular_exponentiation_unit.sv]
// Modular exponentiation unit: result_value = message_value ^ exponent mod modulus.
// Configuration: write modulus (index 0) or exponent (index 1) through cfg_wr_en,
// cfg_index and cfg_data while no transaction is in flight. Both reset to 3233 and 17.
// Input channel in_valid/in_ready carries message_value; output channel
// out_valid/out_ready carries result_value, one result per input.
// One transaction at a time: in_ready is high only when the controller is idle.
// The work is binary square-and-multiply over all VALUE_BITS exponent bits, each
// modular multiply done by a shared shift-and-add unit at one bit per cycle.
// From accept, the unit reduces the message by the modulus, then for each exponent bit
// squares the result and, where the bit is one, multiplies it by the reduced message.
// The next transaction is accepted in the cycle after the result is loaded, at best.
// The result sits in an output register, so a new transaction is accepted while it
// waits; if the receiver still stalls when the next result is ready, the controller
// holds that result until the output register frees.
// A modulus of zero or one gives result 0. Synchronous reset returns modulus and
// exponent to their reset values and drops any transaction in flight.
module rsa_modular_exponentiation_unit #(
  parameter int VALUE_BITS = 31
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [rsa_mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0]                    cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [VALUE_BITS-1:0]                    message_value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [VALUE_BITS-1:0]                    result_value
);
  import rsa_mexp_pkg::*;

  rsa_mexp_cmd_t    cmd;
  rsa_mexp_status_t status;

  rsa_mexp_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsa_mexp_dpath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .message_value (message_value),
    .result_value  (result_value),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
